/* rtl/xtea_pkg.sv */
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and per-stage schedule for the XTEA pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

    // cipher geometry
    localparam int unsigned ROUNDS   = 32;
    localparam int unsigned STAGES   = 2 * ROUNDS;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_KEYS = 4;
    localparam int unsigned KIDX_W   = $clog2(NUM_KEYS);
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 8'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_KEYS-1:0] t_key;

    // item in flight: a is the half being updated, b the half feeding the mix
    typedef struct packed {
        t_word a;
        t_word b;
        logic  dec;
    } t_item;

    // fixed schedule of one half-round stage, for both directions
    typedef struct packed {
        t_word             sum_enc;
        t_word             sum_dec;
        logic [KIDX_W-1:0] kidx_enc;
        logic [KIDX_W-1:0] kidx_dec;
    } t_stage_cst;

    // sum and key index used by half-round stage number stg
    function automatic t_stage_cst stage_cst(input int unsigned stg);
        t_stage_cst  c;
        int unsigned rnd;
        rnd = stg >> 1;
        if ((stg & 1) == 0) begin
            c.sum_enc  = WORD_W'(rnd) * DELTA;
            c.sum_dec  = WORD_W'(ROUNDS - rnd) * DELTA;
            c.kidx_enc = c.sum_enc[KIDX_W-1:0];
            c.kidx_dec = c.sum_dec[11 +: KIDX_W];
        end else begin
            c.sum_enc  = WORD_W'(rnd + 1) * DELTA;
            c.sum_dec  = WORD_W'(ROUNDS - 1 - rnd) * DELTA;
            c.kidx_enc = c.sum_enc[11 +: KIDX_W];
            c.kidx_dec = c.sum_dec[KIDX_W-1:0];
        end
        return c;
    endfunction

endpackage

/* rtl/xtea_in_if.sv */
// ----------------------------------------------------------------------------
// xtea_in_if
// Request channel: one plaintext or ciphertext block and its direction.
// ----------------------------------------------------------------------------
interface xtea_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_low;
    logic [31:0] block_high;
    logic        decrypt;

    modport source (output valid, output block_low, output block_high,
                    output decrypt, input ready);
    modport sink   (input valid, input block_low, input block_high,
                    input decrypt, output ready);
endinterface

/* rtl/xtea_out_if.sv */
// ----------------------------------------------------------------------------
// xtea_out_if
// Result channel: one transformed 64-bit block.
// ----------------------------------------------------------------------------
interface xtea_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_low;
    logic [31:0] out_high;

    modport source (output valid, output out_low, output out_high, input ready);
    modport sink   (input valid, input out_low, input out_high, output ready);
endinterface

/* rtl/xtea_stage.sv */
// ----------------------------------------------------------------------------
// xtea_stage
// One registered half-round: a +/- mix(b), then the halves swap places.
// ----------------------------------------------------------------------------
module xtea_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  xtea_pkg::t_item     i_item,
    input  xtea_pkg::t_key      i_key,
    input  xtea_pkg::t_stage_cst i_cst,
    output logic                o_valid,
    output xtea_pkg::t_item     o_item
);
    import xtea_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    t_word  w_key;
    t_word  w_sum;
    t_word  w_mix;

    // direction picks the schedule constant and key word
    always_comb begin
        w_sum = i_item.dec ? i_cst.sum_dec : i_cst.sum_enc;
        w_key = i_item.dec ? i_key[i_cst.kidx_dec] : i_key[i_cst.kidx_enc];
    end

    // feistel mix and update, halves swapped for the next stage
    always_comb begin
        w_mix = (((i_item.b << 4) ^ (i_item.b >> 5)) + i_item.b) ^ (w_sum + w_key);
        n_item.a   = i_item.b;
        n_item.b   = i_item.dec ? (i_item.a - w_mix) : (i_item.a + w_mix);
        n_item.dec = i_item.dec;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/xtea_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// xtea_block_cipher_unit
// XTEA encrypt/decrypt of 64-bit blocks, 32 rounds, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one request per block: block_low (v0), block_high (v1) and
//         decrypt (0 encrypts, 1 decrypts). o_out returns out_low/out_high.
//   The 128-bit key sits in four 32-bit registers written through
//   i_cfg_we/i_cfg_idx/i_cfg_data (index 0..3, other indexes ignored). Write
//   the key only while no request is in flight.
// Timing:
//   64 register stages, one half-round each (two 32-bit adds deep).
//   A request accepted on i_in passes through every stage register before it
//   shows up on o_out. One request per cycle is sustained while o_out is not stalled.
// Reset:
//   i_rst_n (synchronous, active low) clears all valid bits, the input skid
//   register's valid flag included, and the key words (to zero).
// Backpressure:
//   a stalled result freezes the whole pipeline; i_in.ready is registered,
//   so one more request is caught in a skid register and nothing is lost.
// ----------------------------------------------------------------------------
module xtea_block_cipher_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    xtea_in_if.sink                            i_in,
    xtea_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [xtea_pkg::WORD_W-1:0]        i_cfg_data
);
    import xtea_pkg::*;

    t_key   r_key;
    logic   r_skid_valid;
    t_item  r_skid;
    t_item  w_in_item;
    logic   w_in_fire;
    logic   w_adv;
    logic   w_valid [0:STAGES];
    t_item  w_item  [0:STAGES];

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                REG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                REG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                REG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request decode: decryption updates v1 first
    always_comb begin
        w_in_item.dec = i_in.decrypt;
        w_in_item.a   = i_in.decrypt ? i_in.block_high : i_in.block_low;
        w_in_item.b   = i_in.decrypt ? i_in.block_low  : i_in.block_high;
    end

    assign i_in.ready = !r_skid_valid;
    assign w_in_fire  = i_in.valid && !r_skid_valid;
    assign w_adv      = !w_valid[STAGES] || o_out.ready;

    // skid register catches a request while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            r_skid_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && !w_adv) begin
            r_skid <= w_in_item;
        end
    end

    // pipeline entry
    assign w_valid[0] = r_skid_valid || w_in_fire;
    assign w_item[0]  = r_skid_valid ? r_skid : w_in_item;

    // half-round stages
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam t_stage_cst CST = stage_cst(g);
        xtea_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .i_key   (r_key),
            .i_cst   (CST),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // result: halves back in v0/v1 order
    assign o_out.valid    = w_valid[STAGES];
    assign o_out.out_low  = w_item[STAGES].dec ? w_item[STAGES].b : w_item[STAGES].a;
    assign o_out.out_high = w_item[STAGES].dec ? w_item[STAGES].a : w_item[STAGES].b;

    // a stalled request caught in the skid stays until the pipeline moves
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !w_adv |=> r_skid_valid)
        else $error("skid request dropped during stall");

    // the skid drains on the first advance
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_adv |=> !r_skid_valid)
        else $error("skid request not drained");

    // a request accepted during a stall lands in the skid
    a_skid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && !w_adv |=> r_skid_valid)
        else $error("request lost during stall");

    // entry stage takes the skid before new requests
    a_entry_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_adv |=> g_stage[0].u_stage.o_valid)
        else $error("skid request not moved into pipeline");

endmodule
